FILE: hdl/sre_pkg.sv
`default_nettype none

package sre_pkg;

    // Default upper bound on the radix.
    localparam int MAX_BASE_DEF = 16;

    // Field and register widths.
    localparam int VALUE_W   = 32;
    localparam int SYM_W     = 8;
    localparam int ALPHA_W   = 64;
    localparam int BASE_W    = 5;
    localparam int CFG_IDX_W = 2;
    localparam int DIGIT_SEL_W = 4;

    // Queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;

    // Divider: quotient bits retired per cycle and division steps per digit.
    localparam int DIV_BITS  = 8;
    localparam int DIV_STEPS = VALUE_W / DIV_BITS;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // Digit stack: base 2 gives at most one digit per value bit.
    localparam int STACK_DEPTH = VALUE_W;
    localparam int STACK_IDX_W = $clog2(STACK_DEPTH);
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);

    // Reserved characters.
    localparam logic [SYM_W-1:0] SYM_MINUS   = 8'h2D;
    localparam logic [SYM_W-1:0] SYM_PLUS    = 8'h2B;
    localparam logic [SYM_W-1:0] SYM_STAR    = 8'h2A;
    localparam logic [SYM_W-1:0] SYM_SLASH   = 8'h2F;
    localparam logic [SYM_W-1:0] SYM_PERCENT = 8'h25;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_LOW   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_HIGH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_LENGTH = 2'd2;

    // One number waiting for conversion: sign and unsigned magnitude.
    typedef struct packed {
        logic               neg;
        logic [VALUE_W-1:0] mag;
    } t_job;

    // Back end sequencer states.
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_SIGN,
        BK_EMIT
    } t_back_state;

    // Symbol for digit d out of the two alphabet words.
    function automatic logic [SYM_W-1:0] sym_of(
        input logic [ALPHA_W-1:0]     lo,
        input logic [ALPHA_W-1:0]     hi,
        input logic [DIGIT_SEL_W-1:0] d
    );
        logic [ALPHA_W-1:0] word;
        word = d[3] ? hi : lo;
        return word[{d[2:0], 3'b000} +: SYM_W];
    endfunction

endpackage

`default_nettype wire

FILE: hdl/sre_if.sv
`default_nettype none

// Input stream: one signed value per transfer.
interface sre_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [sre_pkg::VALUE_W-1:0]  value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

// Output stream: one character per transfer, last marks the end of a number.
interface sre_out_if;
    logic                        valid;
    logic                        ready;
    logic [sre_pkg::SYM_W-1:0]   symbol;
    logic                        last;

    modport source (output valid, output symbol, output last, input ready);
    modport sink   (input valid, input symbol, input last, output ready);
endinterface

`default_nettype wire

FILE: hdl/sre_front.sv
`default_nettype none

module sre_front #(
    parameter int MAX_BASE = sre_pkg::MAX_BASE_DEF
) (
    input  wire logic [sre_pkg::ALPHA_W-1:0] i_alpha_low,
    input  wire logic [sre_pkg::ALPHA_W-1:0] i_alpha_high,
    input  wire logic [sre_pkg::BASE_W-1:0]  i_base_length,
    sre_in_if.sink                           i_in,
    input  wire logic                        i_q_full,
    output logic                             o_push,
    output sre_pkg::t_job                    o_job
);

    logic [sre_pkg::SYM_W-1:0] syms [16];
    logic                      bad;
    logic [sre_pkg::VALUE_W-1:0] raw;

    // Unpack the alphabet into one symbol per digit.
    always_comb begin
        for (int a = 0; a < 16; a++) begin
            syms[a] = sre_pkg::sym_of(i_alpha_low, i_alpha_high,
                                      sre_pkg::DIGIT_SEL_W'(a));
        end
    end

    // Alphabet check: radix range, reserved characters, and every pair once.
    always_comb begin
        bad = (i_base_length < sre_pkg::BASE_W'(2)) ||
              (i_base_length > sre_pkg::BASE_W'(MAX_BASE));
        for (int a = 0; a < 16; a++) begin
            if (sre_pkg::BASE_W'(a) < i_base_length) begin
                if ((syms[a] == sre_pkg::SYM_MINUS) || (syms[a] == sre_pkg::SYM_PLUS) ||
                    (syms[a] == sre_pkg::SYM_STAR) || (syms[a] == sre_pkg::SYM_SLASH) ||
                    (syms[a] == sre_pkg::SYM_PERCENT)) begin
                    bad = 1'b1;
                end
                for (int b = a + 1; b < 16; b++) begin
                    if ((sre_pkg::BASE_W'(b) < i_base_length) && (syms[b] == syms[a])) begin
                        bad = 1'b1;
                    end
                end
            end
        end
    end

    // Take a value whenever the queue has room; drop it if the alphabet is bad.
    assign i_in.ready = !i_q_full;
    assign raw        = i_in.value;
    assign o_push     = i_in.valid && !i_q_full && !bad;
    assign o_job.neg  = raw[sre_pkg::VALUE_W-1];
    assign o_job.mag  = raw[sre_pkg::VALUE_W-1] ? (sre_pkg::VALUE_W'(0) - raw) : raw;

endmodule

`default_nettype wire

FILE: hdl/sre_fifo.sv
`default_nettype none

module sre_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire sre_pkg::t_job i_job,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_valid,
    output sre_pkg::t_job      o_job
);

    localparam int DEPTH = sre_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    sre_pkg::t_job       r_mem [DEPTH];
    logic [PTR_W-1:0]    r_wptr;
    logic [PTR_W-1:0]    r_rptr;
    logic [CNT_W-1:0]    r_count;
    logic                do_push;
    logic                do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;
    assign o_job   = r_mem[r_rptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

FILE: hdl/sre_back.sv
`default_nettype none

module sre_back #(
    parameter int MAX_BASE = sre_pkg::MAX_BASE_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic [sre_pkg::ALPHA_W-1:0] i_alpha_low,
    input  wire logic [sre_pkg::ALPHA_W-1:0] i_alpha_high,
    input  wire logic [sre_pkg::BASE_W-1:0]  i_base_length,
    input  wire logic                        i_q_valid,
    input  wire sre_pkg::t_job               i_q_job,
    output logic                             o_pop,
    sre_out_if.source                        o_out
);

    localparam int DIG_W = $clog2(MAX_BASE);
    localparam int RAD_W = $clog2(MAX_BASE + 1);
    localparam int VW    = sre_pkg::VALUE_W;

    sre_pkg::t_back_state r_state, n_state;
    logic [VW-1:0]                 r_work, n_work;
    logic [RAD_W-1:0]              r_rem, n_rem;
    logic [sre_pkg::STEP_W-1:0]    r_step, n_step;
    logic                          r_neg, n_neg;
    logic [sre_pkg::SP_W-1:0]      r_sp, n_sp;
    logic [DIG_W-1:0]              r_stack [sre_pkg::STACK_DEPTH];
    logic                          r_out_valid, n_out_valid;
    logic [sre_pkg::SYM_W-1:0]     r_out_sym, n_out_sym;
    logic                          r_out_last, n_out_last;

    logic [RAD_W-1:0]              radix;
    logic [VW-1:0]                 div_work;
    logic [RAD_W-1:0]              div_rem;
    logic                          digit_done;
    logic                          can_load;
    logic                          push_en;
    logic [sre_pkg::SP_W-1:0]      sp_dec;
    logic [sre_pkg::SYM_W-1:0]     emit_sym;

    assign radix      = i_base_length[RAD_W-1:0];
    assign digit_done = (r_step == sre_pkg::STEP_W'(sre_pkg::DIV_STEPS - 1));
    assign can_load   = !r_out_valid || o_out.ready;
    assign sp_dec     = r_sp - sre_pkg::SP_W'(1);
    assign emit_sym   = sre_pkg::sym_of(i_alpha_low, i_alpha_high,
                            sre_pkg::DIGIT_SEL_W'(r_stack[sp_dec[sre_pkg::STACK_IDX_W-1:0]]));

    // Restoring division by the radix, several quotient bits per cycle.
    always_comb begin : div_slice
        logic [RAD_W:0] t;
        logic           qb;
        div_work = r_work;
        div_rem  = r_rem;
        for (int k = 0; k < sre_pkg::DIV_BITS; k++) begin
            t = {div_rem, div_work[VW-1]};
            if (t >= {1'b0, radix}) begin
                t  = t - {1'b0, radix};
                qb = 1'b1;
            end else begin
                qb = 1'b0;
            end
            div_rem  = t[RAD_W-1:0];
            div_work = {div_work[VW-2:0], qb};
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            sre_pkg::BK_IDLE: begin
                if (i_q_valid) begin
                    n_state = sre_pkg::BK_DIV;
                end
            end
            sre_pkg::BK_DIV: begin
                if (digit_done && (div_work == '0)) begin
                    n_state = r_neg ? sre_pkg::BK_SIGN : sre_pkg::BK_EMIT;
                end
            end
            sre_pkg::BK_SIGN: begin
                if (can_load) begin
                    n_state = sre_pkg::BK_EMIT;
                end
            end
            sre_pkg::BK_EMIT: begin
                if (can_load && (r_sp == sre_pkg::SP_W'(1))) begin
                    n_state = sre_pkg::BK_IDLE;
                end
            end
            default: n_state = sre_pkg::BK_IDLE;
        endcase
    end

    // Datapath and output register.
    always_comb begin
        n_work      = r_work;
        n_rem       = r_rem;
        n_step      = r_step;
        n_neg       = r_neg;
        n_sp        = r_sp;
        n_out_valid = r_out_valid;
        n_out_sym   = r_out_sym;
        n_out_last  = r_out_last;
        push_en     = 1'b0;
        o_pop       = 1'b0;
        // The receiver took the held character.
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            sre_pkg::BK_IDLE: begin
                o_pop = i_q_valid;
                if (i_q_valid) begin
                    n_work = i_q_job.mag;
                    n_neg  = i_q_job.neg;
                    n_rem  = '0;
                    n_step = '0;
                    n_sp   = '0;
                end
            end
            sre_pkg::BK_DIV: begin
                n_work = div_work;
                n_rem  = div_rem;
                n_step = r_step + sre_pkg::STEP_W'(1);
                if (digit_done) begin
                    // Remainder is the next digit; quotient feeds the next pass.
                    push_en = 1'b1;
                    n_sp    = r_sp + sre_pkg::SP_W'(1);
                    n_rem   = '0;
                    n_step  = '0;
                end
            end
            sre_pkg::BK_SIGN: begin
                if (can_load) begin
                    n_out_valid = 1'b1;
                    n_out_sym   = sre_pkg::SYM_MINUS;
                    n_out_last  = 1'b0;
                end
            end
            sre_pkg::BK_EMIT: begin
                // Digits leave the stack most significant first.
                if (can_load) begin
                    n_out_valid = 1'b1;
                    n_out_sym   = emit_sym;
                    n_out_last  = (r_sp == sre_pkg::SP_W'(1));
                    n_sp        = sp_dec;
                end
            end
            default: begin
                n_out_valid = r_out_valid;
            end
        endcase
    end

    // Digit stack.
    always_ff @(posedge i_clk) begin
        if (push_en) begin
            r_stack[r_sp[sre_pkg::STACK_IDX_W-1:0]] <= div_rem[DIG_W-1:0];
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sre_pkg::BK_IDLE;
            r_out_valid <= 1'b0;
            r_sp        <= '0;
            r_step      <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_sp        <= n_sp;
            r_step      <= n_step;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_work     <= n_work;
        r_rem      <= n_rem;
        r_neg      <= n_neg;
        r_out_sym  <= n_out_sym;
        r_out_last <= n_out_last;
    end

    assign o_out.valid  = r_out_valid;
    assign o_out.symbol = r_out_sym;
    assign o_out.last   = r_out_last;

endmodule

`default_nettype wire

FILE: hdl/signed_radix_digit_emitter_core.sv
// Signed radix digit emitter.
// Each transfer on i_in carries a signed 32-bit value. The block writes it as
// text on o_out, one character per transfer: a minus sign for negative values,
// then the digits most significant first with no leading zeros; last is high
// on the final character. The alphabet (up to 16 one-byte symbols) and the
// radix are set through the write port (i_cfg_we, i_cfg_idx, i_cfg_data); the
// user must write them only while the block is idle; the block does not
// enforce this. A bad alphabet makes the block drop values silently. A
// two-entry queue holds accepted values, so i_in stays ready during a
// conversion while the queue has room. The back end pops a number, divides
// the whole 32-bit magnitude by the radix for each digit, eight quotient
// bits per cycle, then sends the characters, one per cycle while the
// receiver is ready. When the receiver holds ready low, the output register
// keeps its character and the converter waits; the queue then fills and i_in
// drops ready. Reset clears the queue, the converter and the configuration
// registers, which leaves the alphabet invalid until it is written.
`default_nettype none

module signed_radix_digit_emitter_core #(
    parameter int MAX_BASE = sre_pkg::MAX_BASE_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [sre_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [sre_pkg::ALPHA_W-1:0]   i_cfg_data,
    sre_in_if.sink                             i_in,
    sre_out_if.source                          o_out
);

    logic [sre_pkg::ALPHA_W-1:0] r_alpha_low;
    logic [sre_pkg::ALPHA_W-1:0] r_alpha_high;
    logic [sre_pkg::BASE_W-1:0]  r_base_length;

    logic          q_full;
    logic          q_push;
    sre_pkg::t_job front_job;
    logic          q_valid;
    logic          q_pop;
    sre_pkg::t_job q_job;

    // Configuration registers; writes to unused indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha_low   <= '0;
            r_alpha_high  <= '0;
            r_base_length <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sre_pkg::CFG_ALPHA_LOW:   r_alpha_low   <= i_cfg_data;
                sre_pkg::CFG_ALPHA_HIGH:  r_alpha_high  <= i_cfg_data;
                sre_pkg::CFG_BASE_LENGTH: r_base_length <= i_cfg_data[sre_pkg::BASE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Front end: accepts values, checks the alphabet, forms sign and magnitude.
    sre_front #(
        .MAX_BASE (MAX_BASE)
    ) u_front (
        .i_alpha_low   (r_alpha_low),
        .i_alpha_high  (r_alpha_high),
        .i_base_length (r_base_length),
        .i_in          (i_in),
        .i_q_full      (q_full),
        .o_push        (q_push),
        .o_job         (front_job)
    );

    // Queue between front and back.
    sre_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (front_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    // Back end: digit generation and character output.
    sre_back #(
        .MAX_BASE (MAX_BASE)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_alpha_low   (r_alpha_low),
        .i_alpha_high  (r_alpha_high),
        .i_base_length (r_base_length),
        .i_q_valid     (q_valid),
        .i_q_job       (q_job),
        .o_pop         (q_pop),
        .o_out         (o_out)
    );

endmodule

`default_nettype wire
